// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the NAL unit classifier.
// The macros expect a clock named clk_i and an active-low reset named rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define NALC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define NALC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hdl/nalc_pkg.sv -----
// Package of the NAL unit classifier: phase codes, NAL and slice type codes,
// the transaction and parser state types, and the per-bit Exp-Golomb step.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package nalc_pkg;

  localparam int unsigned MaxPrefix = 32;
  localparam logic [5:0] MaxPrefixCnt = 6'(MaxPrefix);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhOther = 3'd1;
  localparam logic [2:0] PhP1    = 3'd2;
  localparam logic [2:0] PhS1    = 3'd3;
  localparam logic [2:0] PhP2    = 3'd4;
  localparam logic [2:0] PhS2    = 3'd5;
  localparam logic [2:0] PhDone  = 3'd6;

  localparam logic [7:0] EpbByte = 8'h03;
  localparam logic [15:0] HistReset = 16'hffff;

  localparam logic [4:0] NalTypeSliceLo = 5'd1;
  localparam logic [4:0] NalTypeSliceHi = 5'd5;
  localparam logic [4:0] NalTypeSps = 5'd7;
  localparam logic [4:0] NalTypePps = 5'd8;

  localparam logic [31:0] SliceTypeI     = 32'd2;
  localparam logic [31:0] SliceTypeSi    = 32'd4;
  localparam logic [31:0] SliceTypeIAll  = 32'd7;
  localparam logic [31:0] SliceTypeSiAll = 32'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       unit_start;
    logic       unit_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  unit_type;
    logic [1:0]  ref_level;
    logic        is_slice;
    logic [31:0] first_macroblock;
    logic [31:0] slice_kind;
    logic        key_unit;
    logic        truncated;
    logic        code_error;
  } result_t;

  // The current code is kept as its prefix length and suffix bits; the first
  // code, once complete, is held in the same form.
  typedef struct packed {
    logic [2:0]  phase;
    logic [5:0]  pfx;
    logic [5:0]  sleft;
    logic [31:0] acc;
    logic [4:0]  fm_p;
    logic [31:0] fm_s;
    logic        err;
    logic        err_first;
  } parse_st_t;

  // Value of a code with p leading zeros and suffix s: 2^p - 1 + s.
  function automatic logic [31:0] code_value(logic [4:0] p, logic [31:0] s);
    return ~(32'hffff_ffff << p) + s;
  endfunction

  function automatic parse_st_t bit_step(parse_st_t st, logic b);
    parse_st_t   nx;
    logic [5:0]  pinc;
    logic [5:0]  sdec;
    logic [31:0] snew;
    nx   = st;
    pinc = st.pfx + 6'd1;
    sdec = st.sleft - 6'd1;
    snew = {st.acc[30:0], b};
    case (st.phase)
      PhP1, PhP2: begin
        if (!b) begin
          nx.pfx = pinc;
          if (pinc >= MaxPrefixCnt) begin
            nx.err       = 1'b1;
            nx.err_first = (st.phase == PhP1);
            nx.phase     = PhDone;
          end
        end else if (st.pfx == 6'd0) begin
          if (st.phase == PhP1) begin
            nx.fm_p  = 5'd0;
            nx.fm_s  = '0;
            nx.phase = PhP2;
            nx.acc   = '0;
          end else begin
            nx.phase = PhDone;
          end
        end else begin
          nx.sleft = st.pfx;
          nx.acc   = '0;
          nx.phase = (st.phase == PhP1) ? PhS1 : PhS2;
        end
      end
      PhS1, PhS2: begin
        nx.acc   = snew;
        nx.sleft = sdec;
        if (sdec == 6'd0) begin
          if (st.phase == PhS1) begin
            nx.fm_p  = st.pfx[4:0];
            nx.fm_s  = snew;
            nx.phase = PhP2;
            nx.pfx   = 6'd0;
            nx.acc   = '0;
          end else begin
            nx.phase = PhDone;
          end
        end
      end
      default: begin
      end
    endcase
    return nx;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/nalc_in_stage.sv -----
// Input register of the NAL unit classifier: holds one byte transaction.
// Depends on nalc_pkg for the transaction type.
`timescale 1ns / 1ps
`default_nettype none

module nalc_in_stage
  import nalc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire in_item_t item_i,
  input  wire logic     step_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || step_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- hdl/nalc_parser.sv -----
// Parser state of the NAL unit classifier: header capture, emulation-prevention
// filter and an eight-bit unrolled Exp-Golomb decoder, plus result formation.
// Depends on nalc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nalc_parser
  import nalc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  output result_t       res_o
);

  parse_st_t   st_q;
  parse_st_t   st_d;
  parse_st_t   st_post;
  parse_st_t   st_chain;
  parse_st_t   st_start;
  logic [15:0] hist_q;
  logic [15:0] hist_d;
  logic        skip_q;
  logic        skip_d;
  logic [6:0]  hdr_q;
  logic [6:0]  hdr_d;
  logic        drop;
  logic        active;
  logic [4:0]  type_d;
  logic        slice_d;
  logic [31:0] cur_val;
  logic [31:0] fm_val;

  assign drop   = !skip_q && (item_i.data_byte == EpbByte) && (hist_q == 16'h0000);
  assign active = st_q.phase inside {[PhP1:PhS2]};
  assign type_d = hdr_d[4:0];
  assign slice_d = type_d inside {[NalTypeSliceLo:NalTypeSliceHi]};

  always_comb begin
    st_chain = st_q;
    for (int i = 7; i >= 0; i--) begin
      st_chain = bit_step(st_chain, item_i.data_byte[i]);
    end
  end

  always_comb begin
    st_start       = '0;
    st_start.phase = (item_i.data_byte[4:0] inside {[NalTypeSliceLo:NalTypeSliceHi]})
                     ? PhP1 : PhOther;
  end

  always_comb begin
    st_post = st_q;
    hist_d  = hist_q;
    skip_d  = skip_q;
    hdr_d   = hdr_q;
    if (item_i.unit_start) begin
      st_post = st_start;
      hist_d  = HistReset;
      skip_d  = 1'b0;
      hdr_d   = item_i.data_byte[6:0];
    end else if (active) begin
      if (drop) begin
        skip_d = 1'b1;
      end else begin
        skip_d  = 1'b0;
        hist_d  = {hist_q[7:0], item_i.data_byte};
        st_post = st_chain;
      end
    end
  end

  assign res_valid_o = item_i.unit_end && (item_i.unit_start || (st_q.phase != PhIdle));

  always_comb begin
    st_d = st_post;
    if (res_valid_o) begin
      st_d.phase = PhIdle;
    end
  end

  assign cur_val = code_value(st_post.pfx[4:0], st_post.acc);
  assign fm_val  = code_value(st_post.fm_p, st_post.fm_s);

  always_comb begin
    res_o                  = '0;
    res_o.unit_type        = type_d;
    res_o.ref_level        = hdr_d[6:5];
    res_o.is_slice         = slice_d;
    case (st_post.phase)
      PhP1, PhS1: begin
        res_o.first_macroblock = cur_val;
        res_o.truncated        = 1'b1;
      end
      PhP2, PhS2: begin
        res_o.first_macroblock = fm_val;
        res_o.slice_kind       = cur_val;
        res_o.truncated        = 1'b1;
      end
      PhDone: begin
        res_o.first_macroblock = (st_post.err && st_post.err_first) ? '1 : fm_val;
        if (st_post.err) begin
          res_o.slice_kind = st_post.err_first ? '0 : '1;
        end else begin
          res_o.slice_kind = cur_val;
        end
      end
      default: begin
      end
    endcase
    res_o.code_error = st_post.err;
    if (slice_d) begin
      res_o.key_unit = (res_o.slice_kind == SliceTypeI) || (res_o.slice_kind == SliceTypeSi)
                    || (res_o.slice_kind == SliceTypeIAll)
                    || (res_o.slice_kind == SliceTypeSiAll);
    end else begin
      res_o.key_unit = (type_d == NalTypeSps) || (type_d == NalTypePps);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= '0;
      hist_q <= HistReset;
      skip_q <= 1'b0;
      hdr_q  <= '0;
    end else if (step_i) begin
      st_q   <= st_d;
      hist_q <= hist_d;
      skip_q <= skip_d;
      hdr_q  <= hdr_d;
    end
  end

  `NALC_ASSERT(a_err_not_truncated, res_valid_o |-> !(res_o.code_error && res_o.truncated), "code error reported together with truncation")
  `NALC_ASSERT(a_idle_after_result, (step_i && res_valid_o) |=> (st_q.phase == PhIdle), "parser not idle after a result")
  `NALC_ASSERT_NEVER(a_skip_needs_zeros, skip_q && (hist_q != 16'h0000), "emulation byte dropped without two zero bytes")
  `NALC_ASSERT(a_nonslice_zero, (res_valid_o && !res_o.is_slice) |-> ((res_o.first_macroblock == 32'd0) && (res_o.slice_kind == 32'd0)), "non-slice unit carries decoded values")

endmodule

`default_nettype wire

// ----- hdl/nalc_out_reg.sv -----
// Result register of the NAL unit classifier: holds one result transaction
// until the receiver takes it. Depends on nalc_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module nalc_out_reg
  import nalc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    ready_i,
  output logic         valid_o,
  output result_t      res_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ----- hdl/h264_nal_slice_header_classifier_core.sv -----
// Top level of the H.264 NAL unit classifier.
// Instantiates nalc_in_stage, nalc_parser and nalc_out_reg; depends on nalc_pkg.
//
// Usage: NAL unit bytes enter on the input channel (in_valid_i/in_ready_o), one
// byte per transaction, the header byte marked by unit_start_i and the last
// byte by unit_end_i. Bytes outside a unit are ignored. One result transaction
// per unit leaves on the output channel (out_valid_o/out_ready_i) carrying the
// header fields, the two decoded slice header codes and the status flags.
// An accepted byte is registered in the input register; all eight bits then
// pass an unrolled Exp-Golomb decoder between the input register and the
// result register. The result of a unit is loaded into the result register
// when the last byte of the unit leaves the input register. Throughput is one
// byte per cycle while the receiver does not stall the result register.
// When the receiver stalls, the result register holds its transaction and the
// input register fills; in_ready_o then drops until the result is taken.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to idle, waiting for a header byte.
`timescale 1ns / 1ps
`default_nettype none

module h264_nal_slice_header_classifier_core
  import nalc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        unit_start_i,
  input  wire logic        unit_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       unit_type_o,
  output logic [1:0]       ref_level_o,
  output logic             is_slice_o,
  output logic [31:0]      first_macroblock_o,
  output logic [31:0]      slice_kind_o,
  output logic             key_unit_o,
  output logic             truncated_o,
  output logic             code_error_o
);

  in_item_t in_item;
  in_item_t st1_item;
  logic     st1_valid;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte  = data_byte_i;
  assign in_item.unit_start = unit_start_i;
  assign in_item.unit_end   = unit_end_i;

  assign advance = st1_valid && (!out_valid_o || out_ready_i);

  nalc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .step_i  (advance),
    .valid_o (st1_valid),
    .item_o  (st1_item)
  );

  nalc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (st1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nalc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign unit_type_o        = out_res.unit_type;
  assign ref_level_o        = out_res.ref_level;
  assign is_slice_o         = out_res.is_slice;
  assign first_macroblock_o = out_res.first_macroblock;
  assign slice_kind_o       = out_res.slice_kind;
  assign key_unit_o         = out_res.key_unit;
  assign truncated_o        = out_res.truncated;
  assign code_error_o       = out_res.code_error;

endmodule

`default_nettype wire
